>>> design/desf_pkg.sv
`default_nettype none

package desf_pkg;

   // Field and register widths
   localparam int CNT_W     = 16;
   localparam int TOT_W     = 32;
   localparam int SCALE_W   = 25;
   localparam int ALPHA_W   = 9;
   localparam int VF_W      = 20;
   localparam int GAIN_W    = 24;
   localparam int RPM_W     = 25;
   localparam int SPEED_W   = 32;

   // Internal arithmetic widths
   localparam int SMOOTH_W  = 48;
   localparam int FRAC_W    = 16;
   localparam int RPMQ_W    = SMOOTH_W - FRAC_W;
   localparam int MUL_W     = RPM_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int FSHIFT    = ALPHA_W - 1;
   localparam int FDIFF_W   = SMOOTH_W + 1;
   localparam int FPROD_W   = FDIFF_W + ALPHA_W + 1;
   localparam int VEL_W     = RPM_W + VF_W;
   localparam int MAG_W     = VEL_W;
   localparam int GAIN_FRAC = 24;
   localparam int Q_W       = MAG_W + 1;

   // Configuration port
   localparam int DATA_W    = 32;
   localparam int ADDR_LSB  = 2;
   localparam int ADDR_W    = ADDR_LSB + 2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FSHIFT;
   localparam int FBIAS = (1 << FSHIFT) - 1;
   localparam int RBIAS = (1 << FRAC_W) - 1;

   localparam logic signed [PROD_W-1:0] RAW_MAX = PROD_W'({(SMOOTH_W-1){1'b1}});
   localparam logic signed [PROD_W-1:0] RAW_MIN = ~RAW_MAX;

   localparam logic signed [RPMQ_W-1:0] RPM_HI = RPMQ_W'(1) <<< (RPM_W - 2);
   localparam logic signed [RPMQ_W-1:0] RPM_LO = -RPM_HI;

   localparam logic signed [SPEED_W-1:0] S32_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] S32_MIN = ~S32_MAX;
   localparam logic signed [VEL_W:0] LIN_MAX = (VEL_W+1)'(S32_MAX);
   localparam logic signed [VEL_W:0] LIN_MIN = (VEL_W+1)'(S32_MIN);
   localparam logic [Q_W-1:0] TURN_LIM = Q_W'(1) << (SPEED_W - 1);

   typedef enum logic [1:0] {
      REG_RPM_SCALE,
      REG_FILTER_ALPHA,
      REG_VELOCITY_FACTOR,
      REG_ANGULAR_GAIN
   } reg_idx_type;

   typedef struct packed {
      logic [SCALE_W-1:0] rpm_scale;
      logic [ALPHA_W-1:0] filter_alpha;
      logic [VF_W-1:0]    velocity_factor;
      logic [GAIN_W-1:0]  angular_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rpm_scale:       SCALE_W'(65536),
      filter_alpha:    ALPHA_W'(179),
      velocity_factor: VF_W'(3403),
      angular_gain:    GAIN_W'(111848)
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RAW,
      OP_FMUL,
      OP_FADD,
      OP_RPM,
      OP_VEL,
      OP_COMB,
      OP_TURN_HI,
      OP_TURN_LO,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   wheel;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW_L,
      ST_FMUL_L,
      ST_FADD_L,
      ST_RPM_L,
      ST_RAW_R,
      ST_FMUL_R,
      ST_FADD_R,
      ST_RPM_R,
      ST_VEL_L,
      ST_VEL_R,
      ST_COMB,
      ST_TURN_HI,
      ST_TURN_LO,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> design/desf_csr.sv
`default_nettype none

module desf_csr import desf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        write_en;

   assign idx      = reg_idx_type'(paddr[ADDR_W-1:ADDR_LSB]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (write_en) begin
         case (idx)
            REG_RPM_SCALE:       cfg_ff.rpm_scale       <= pwdata[SCALE_W-1:0];
            REG_FILTER_ALPHA:    cfg_ff.filter_alpha    <= pwdata[ALPHA_W-1:0];
            REG_VELOCITY_FACTOR: cfg_ff.velocity_factor <= pwdata[VF_W-1:0];
            REG_ANGULAR_GAIN:    cfg_ff.angular_gain    <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RPM_SCALE:       prdata = DATA_W'(cfg_ff.rpm_scale);
         REG_FILTER_ALPHA:    prdata = DATA_W'(cfg_ff.filter_alpha);
         REG_VELOCITY_FACTOR: prdata = DATA_W'(cfg_ff.velocity_factor);
         REG_ANGULAR_GAIN:    prdata = DATA_W'(cfg_ff.angular_gain);
         default:             prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> design/desf_ctrl.sv
`default_nettype none

module desf_ctrl import desf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.wheel    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_RAW_L;
            end
         end
         ST_RAW_L: begin
            cmd.op   = OP_RAW;
            state_in = ST_FMUL_L;
         end
         ST_FMUL_L: begin
            cmd.op   = OP_FMUL;
            state_in = ST_FADD_L;
         end
         ST_FADD_L: begin
            cmd.op   = OP_FADD;
            state_in = ST_RPM_L;
         end
         ST_RPM_L: begin
            cmd.op   = OP_RPM;
            state_in = ST_RAW_R;
         end
         ST_RAW_R: begin
            cmd.op    = OP_RAW;
            cmd.wheel = 1'b1;
            state_in  = ST_FMUL_R;
         end
         ST_FMUL_R: begin
            cmd.op    = OP_FMUL;
            cmd.wheel = 1'b1;
            state_in  = ST_FADD_R;
         end
         ST_FADD_R: begin
            cmd.op    = OP_FADD;
            cmd.wheel = 1'b1;
            state_in  = ST_RPM_R;
         end
         ST_RPM_R: begin
            cmd.op    = OP_RPM;
            cmd.wheel = 1'b1;
            state_in  = ST_VEL_L;
         end
         ST_VEL_L: begin
            cmd.op   = OP_VEL;
            state_in = ST_VEL_R;
         end
         ST_VEL_R: begin
            cmd.op    = OP_VEL;
            cmd.wheel = 1'b1;
            state_in  = ST_COMB;
         end
         ST_COMB: begin
            cmd.op   = OP_COMB;
            state_in = ST_TURN_HI;
         end
         ST_TURN_HI: begin
            cmd.op   = OP_TURN_HI;
            state_in = ST_TURN_LO;
         end
         ST_TURN_LO: begin
            cmd.op   = OP_TURN_LO;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free or being drained
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/desf_dp.sv
`default_nettype none

module desf_dp import desf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  cfg_type                   cfg,
   input  logic [CNT_W-1:0]          req_left_count,
   input  logic [CNT_W-1:0]          req_right_count,
   output logic signed [TOT_W-1:0]   rsp_left_total,
   output logic signed [TOT_W-1:0]   rsp_right_total,
   output logic signed [RPM_W-1:0]   rsp_left_rpm,
   output logic signed [RPM_W-1:0]   rsp_right_rpm,
   output logic signed [SPEED_W-1:0] rsp_linear_speed,
   output logic signed [SPEED_W-1:0] rsp_turn_rate
);

   // architectural state
   logic                       primed_ff;
   logic [CNT_W-1:0]           prev_ff   [2];
   logic signed [TOT_W-1:0]    total_ff  [2];
   logic signed [SMOOTH_W-1:0] smooth_ff [2];

   // working registers
   logic signed [CNT_W-1:0]    delta_ff  [2];
   logic signed [SMOOTH_W-1:0] raw_ff;
   logic signed [FPROD_W-1:0]  fprod_ff;
   logic signed [RPM_W-1:0]    rpm_ff    [2];
   logic signed [VEL_W-1:0]    vel_ff    [2];
   logic signed [SPEED_W-1:0]  lin_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic [MAG_W-1:0]           hi_ff;
   logic [Q_W-1:0]             q_ff;

   // output register
   logic signed [TOT_W-1:0]    out_ltot_ff, out_rtot_ff;
   logic signed [RPM_W-1:0]    out_lrpm_ff, out_rrpm_ff;
   logic signed [SPEED_W-1:0]  out_lin_ff, out_turn_ff;

   // next values and intermediates
   logic [CNT_W-1:0]           count_l, count_r;
   logic signed [CNT_W-1:0]    delta_l_in, delta_r_in;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [SMOOTH_W-1:0] raw_in;
   logic [ALPHA_W-1:0]         alpha_eff;
   logic signed [ALPHA_W:0]    alpha_s;
   logic signed [FDIFF_W-1:0]  fdiff;
   logic signed [FPROD_W-1:0]  fprod_in;
   logic signed [FPROD_W-1:0]  ftotal, fbias, fround;
   logic signed [SMOOTH_W-1:0] smooth_in;
   logic signed [SMOOTH_W-1:0] rbias, rsum;
   logic signed [RPMQ_W-1:0]   rq;
   logic signed [RPM_W-1:0]    rpm_in;
   logic signed [VEL_W:0]      vsum, vround, vhalf, vdiff, vmag;
   logic signed [SPEED_W-1:0]  lin_in;
   logic [MAG_W-1:0]           mag_in;
   logic [Q_W-1:0]             q_in;
   logic [SPEED_W-1:0]         q32;
   logic signed [SPEED_W-1:0]  turn_in;

   always_comb begin
      // the right counter runs the other way
      count_l    = req_left_count;
      count_r    = CNT_W'(0) - req_right_count;
      delta_l_in = primed_ff ? signed'(CNT_W'(count_l - prev_ff[0])) : '0;
      delta_r_in = primed_ff ? signed'(CNT_W'(count_r - prev_ff[1])) : '0;

      // shared multiplier: raw rpm, wheel speed and both halves of the turn product
      case (cmd.op)
         OP_RAW: begin
            mul_a = MUL_W'(delta_ff[cmd.wheel]);
            mul_b = signed'(MUL_W'(cfg.rpm_scale));
         end
         OP_VEL: begin
            mul_a = MUL_W'(rpm_ff[cmd.wheel]);
            mul_b = signed'(MUL_W'(cfg.velocity_factor));
         end
         OP_TURN_HI: begin
            mul_a = signed'(MUL_W'(mag_ff[MAG_W-1:GAIN_FRAC]));
            mul_b = signed'(MUL_W'(cfg.angular_gain));
         end
         OP_TURN_LO: begin
            mul_a = signed'(MUL_W'(mag_ff[GAIN_FRAC-1:0]));
            mul_b = signed'(MUL_W'(cfg.angular_gain));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;

      if (mul_p > RAW_MAX) begin
         raw_in = SMOOTH_W'(RAW_MAX);
      end else if (mul_p < RAW_MIN) begin
         raw_in = SMOOTH_W'(RAW_MIN);
      end else begin
         raw_in = SMOOTH_W'(mul_p);
      end

      // 256*s + a*(raw - s), then divide by 256 toward zero
      alpha_eff = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
      alpha_s   = signed'({1'b0, alpha_eff});
      fdiff     = FDIFF_W'(raw_ff) - FDIFF_W'(smooth_ff[cmd.wheel]);
      fprod_in  = alpha_s * fdiff;
      ftotal    = (FPROD_W'(smooth_ff[cmd.wheel]) <<< FSHIFT) + fprod_ff;
      fbias     = ftotal[FPROD_W-1] ? FPROD_W'(FBIAS) : '0;
      fround    = ftotal + fbias;
      smooth_in = fround[FSHIFT +: SMOOTH_W];

      // integer rpm toward zero, then saturate
      rbias = smooth_ff[cmd.wheel][SMOOTH_W-1] ? SMOOTH_W'(RBIAS) : '0;
      rsum  = smooth_ff[cmd.wheel] + rbias;
      rq    = rsum[SMOOTH_W-1:FRAC_W];
      if (rq > RPM_HI) begin
         rpm_in = RPM_W'(RPM_HI);
      end else if (rq < RPM_LO) begin
         rpm_in = RPM_W'(RPM_LO);
      end else begin
         rpm_in = RPM_W'(rq);
      end

      // mean speed toward zero, and magnitude and sign of the speed difference
      vsum   = (VEL_W+1)'(vel_ff[0]) + (VEL_W+1)'(vel_ff[1]);
      vround = vsum + ((vsum[VEL_W]) ? (VEL_W+1)'(1) : (VEL_W+1)'(0));
      vhalf  = vround >>> 1;
      if (vhalf > LIN_MAX) begin
         lin_in = S32_MAX;
      end else if (vhalf < LIN_MIN) begin
         lin_in = S32_MIN;
      end else begin
         lin_in = SPEED_W'(vhalf);
      end
      vdiff  = (VEL_W+1)'(vel_ff[1]) - (VEL_W+1)'(vel_ff[0]);
      vmag   = vdiff[VEL_W] ? (VEL_W+1)'(0) - vdiff : vdiff;
      mag_in = vmag[MAG_W-1:0];

      q_in = Q_W'(hi_ff) + Q_W'(mul_p[GAIN_FRAC+GAIN_W-1:GAIN_FRAC]);

      q32 = q_ff[SPEED_W-1:0];
      if (q_ff >= TURN_LIM) begin
         turn_in = neg_ff ? S32_MIN : S32_MAX;
      end else begin
         turn_in = neg_ff ? signed'(SPEED_W'(0) - q32) : signed'(q32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         total_ff[0]  <= '0;
         total_ff[1]  <= '0;
         smooth_ff[0] <= '0;
         smooth_ff[1] <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               primed_ff  <= 1'b1;
               prev_ff[0] <= count_l;
               prev_ff[1] <= count_r;
            end
            OP_RAW:  total_ff[cmd.wheel]  <= total_ff[cmd.wheel] + TOT_W'(delta_ff[cmd.wheel]);
            OP_FADD: smooth_ff[cmd.wheel] <= smooth_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            delta_ff[0] <= delta_l_in;
            delta_ff[1] <= delta_r_in;
         end
         OP_RAW:     raw_ff <= raw_in;
         OP_FMUL:    fprod_ff <= fprod_in;
         OP_RPM:     rpm_ff[cmd.wheel] <= rpm_in;
         OP_VEL:     vel_ff[cmd.wheel] <= mul_p[VEL_W-1:0];
         OP_COMB: begin
            lin_ff <= lin_in;
            mag_ff <= mag_in;
            neg_ff <= vdiff[VEL_W];
         end
         OP_TURN_HI: hi_ff <= mul_p[MAG_W-1:0];
         OP_TURN_LO: q_ff <= q_in;
         OP_OUT: begin
            out_ltot_ff <= total_ff[0];
            out_rtot_ff <= total_ff[1];
            out_lrpm_ff <= rpm_ff[0];
            out_rrpm_ff <= rpm_ff[1];
            out_lin_ff  <= lin_ff;
            out_turn_ff <= turn_in;
         end
         default: ;
      endcase
   end

   assign rsp_left_total   = out_ltot_ff;
   assign rsp_right_total  = out_rtot_ff;
   assign rsp_left_rpm     = out_lrpm_ff;
   assign rsp_right_rpm    = out_rrpm_ff;
   assign rsp_linear_speed = out_lin_ff;
   assign rsp_turn_rate    = out_turn_ff;

endmodule

`default_nettype wire

>>> design/dual_encoder_speed_filter.sv
// A req word is taken only while idle; the controller sequence then runs
// both wheels in turn through one shared 26x26 multiplier and one filter
// multiplier, and takes no new word until the result is in the output
// register. A waiting rsp word stalls only the final step.
// Reset (synchronous): counts, tick totals and filters clear, registers take
// their defaults; the first word after reset only primes the last counts.
`default_nettype none

module dual_encoder_speed_filter import desf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CNT_W-1:0]          req_left_count,
   input  logic [CNT_W-1:0]          req_right_count,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [TOT_W-1:0]   rsp_left_total,
   output logic signed [TOT_W-1:0]   rsp_right_total,
   output logic signed [RPM_W-1:0]   rsp_left_rpm,
   output logic signed [RPM_W-1:0]   rsp_right_rpm,
   output logic signed [SPEED_W-1:0] rsp_linear_speed,
   output logic signed [SPEED_W-1:0] rsp_turn_rate,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   cfg_type cfg;
   cmd_type cmd;

   desf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   desf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   desf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_left_count   (req_left_count),
      .req_right_count  (req_right_count),
      .rsp_left_total   (rsp_left_total),
      .rsp_right_total  (rsp_right_total),
      .rsp_left_rpm     (rsp_left_rpm),
      .rsp_right_rpm    (rsp_right_rpm),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_turn_rate    (rsp_turn_rate)
   );

endmodule

`default_nettype wire

>>> design/desf_check.sv
`default_nettype none

module desf_check (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire signed [31:0] rsp_left_total,
   input wire signed [31:0] rsp_turn_rate
);

   // one word in flight: a taken req word blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req accepted while a word is still in work");

   // a new result only appears at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp word appeared without a word in work");

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_left_total) && $stable(rsp_turn_rate)))
      else $error("stalled rsp word changed or dropped");

   // reset leaves the block empty and ready
   assert property (@(posedge clock)
      $fell(reset) |-> (!req_stall && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind dual_encoder_speed_filter desf_check u_desf_check (.*);

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
   import desf_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam longint RPM_LIMIT = 64'sd8388608;
   localparam longint RAW_HIGH = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint RAW_LOW = -RAW_HIGH - 1;
   localparam longint SPEED_HIGH = 64'sd2147483647;
   localparam longint SPEED_LOW = -64'sd2147483648;

   typedef struct {
      logic signed [TOT_W-1:0]   left_total;
      logic signed [TOT_W-1:0]   right_total;
      logic signed [RPM_W-1:0]   left_rpm;
      logic signed [RPM_W-1:0]   right_rpm;
      logic signed [SPEED_W-1:0] linear_speed;
      logic signed [SPEED_W-1:0] turn_rate;
   } speed_report_type;

   class wheel_speed_scoreboard;
      logic [SCALE_W-1:0] rpm_scale;
      logic [ALPHA_W-1:0] alpha;
      logic [VF_W-1:0]    vel_factor;
      logic [GAIN_W-1:0]  turn_gain;
      logic [CNT_W-1:0]   last_left;
      logic [CNT_W-1:0]   last_right;
      logic [TOT_W-1:0]   ticks_left;
      logic [TOT_W-1:0]   ticks_right;
      longint             smooth_left;
      longint             smooth_right;
      bit                 primed;
      speed_report_type   pending_speeds[$];
      int                 mismatches;
      int                 reports_checked;

      function new();
         rpm_scale = CFG_RESET.rpm_scale;
         alpha = CFG_RESET.filter_alpha;
         vel_factor = CFG_RESET.velocity_factor;
         turn_gain = CFG_RESET.angular_gain;
         last_left = '0;
         last_right = '0;
         ticks_left = '0;
         ticks_right = '0;
         smooth_left = 0;
         smooth_right = 0;
         primed = 1'b0;
         mismatches = 0;
         reports_checked = 0;
      endfunction

      function logic [DATA_W-1:0] set_register(reg_idx_type idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_RPM_SCALE: begin
               rpm_scale = value[SCALE_W-1:0];
               return DATA_W'(rpm_scale);
            end
            REG_FILTER_ALPHA: begin
               alpha = value[ALPHA_W-1:0];
               return DATA_W'(alpha);
            end
            REG_VELOCITY_FACTOR: begin
               vel_factor = value[VF_W-1:0];
               return DATA_W'(vel_factor);
            end
            REG_ANGULAR_GAIN: begin
               turn_gain = value[GAIN_W-1:0];
               return DATA_W'(turn_gain);
            end
            default: return '0;
         endcase
      endfunction

      function longint clamp_to(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Advance one wheel's filter and return its saturated integer rpm.
      function longint filter_rpm(longint delta, inout longint smooth);
         longint a;
         longint raw;
         a = (alpha > 9'd256) ? 64'sd256 : longint'(alpha);
         raw = clamp_to(delta * longint'(rpm_scale), RAW_LOW, RAW_HIGH);
         smooth = (a * raw + (64'sd256 - a) * smooth) / 64'sd256;
         return clamp_to(smooth / 64'sd65536, -RPM_LIMIT, RPM_LIMIT);
      endfunction

      function logic signed [SPEED_W-1:0] turn_rate_of(longint diff);
         logic [63:0] mag;
         logic [63:0] q;
         longint      r;
         mag = (diff < 0) ? -diff : diff;
         q = (mag >> 24) * turn_gain + (((mag & 64'hFF_FFFF) * turn_gain) >> 24);
         if (q > 64'h8000_0000)
            q = 64'h8000_0000;
         if (diff < 0)
            r = -longint'(q);
         else
            r = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
         return SPEED_W'(r);
      endfunction

      function void note_counts(logic [CNT_W-1:0] left, logic [CNT_W-1:0] right);
         logic [CNT_W-1:0]        cl;
         logic [CNT_W-1:0]        cr;
         logic signed [CNT_W-1:0] dl;
         logic signed [CNT_W-1:0] dr;
         longint                  rl;
         longint                  rr;
         longint                  vl;
         longint                  vr;
         speed_report_type        rep;
         cl = left;
         cr = -right;
         dl = '0;
         dr = '0;
         if (primed) begin
            dl = cl - last_left;
            dr = cr - last_right;
         end
         primed = 1'b1;
         last_left = cl;
         last_right = cr;
         ticks_left = ticks_left + TOT_W'(dl);
         ticks_right = ticks_right + TOT_W'(dr);
         rl = filter_rpm(dl, smooth_left);
         rr = filter_rpm(dr, smooth_right);
         vl = rl * longint'(vel_factor);
         vr = rr * longint'(vel_factor);
         rep.left_total = ticks_left;
         rep.right_total = ticks_right;
         rep.left_rpm = RPM_W'(rl);
         rep.right_rpm = RPM_W'(rr);
         rep.linear_speed = SPEED_W'(clamp_to((vl + vr) / 2, SPEED_LOW, SPEED_HIGH));
         rep.turn_rate = turn_rate_of(vr - vl);
         pending_speeds.push_back(rep);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_report(speed_report_type got);
         speed_report_type want;
         if (pending_speeds.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: speed word expected none actual left_total %0d",
                        $time, got.left_total);
            return;
         end
         want = pending_speeds.pop_front();
         compare_field("left_total", want.left_total, got.left_total);
         compare_field("right_total", want.right_total, got.right_total);
         compare_field("left_rpm", want.left_rpm, got.left_rpm);
         compare_field("right_rpm", want.right_rpm, got.right_rpm);
         compare_field("linear_speed", want.linear_speed, got.linear_speed);
         compare_field("turn_rate", want.turn_rate, got.turn_rate);
         reports_checked++;
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CNT_W-1:0]          req_left_count = '0;
   logic [CNT_W-1:0]          req_right_count = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [TOT_W-1:0]   rsp_left_total;
   logic signed [TOT_W-1:0]   rsp_right_total;
   logic signed [RPM_W-1:0]   rsp_left_rpm;
   logic signed [RPM_W-1:0]   rsp_right_rpm;
   logic signed [SPEED_W-1:0] rsp_linear_speed;
   logic signed [SPEED_W-1:0] rsp_turn_rate;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [DATA_W-1:0]         pwdata = '0;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   wheel_speed_scoreboard sb;
   int                    sender_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   bit                    wait_for_drain = 1'b0;
   int                    words_sent = 0;
   int                    settings_written = 0;
   int                    cycle_count = 0;
   logic [CNT_W-1:0]      left_pos = '0;
   logic [CNT_W-1:0]      right_pos = '0;

   dual_encoder_speed_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_count   (req_left_count),
      .req_right_count  (req_right_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_total   (rsp_left_total),
      .rsp_right_total  (rsp_right_total),
      .rsp_left_rpm     (rsp_left_rpm),
      .rsp_right_rpm    (rsp_right_rpm),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_turn_rate    (rsp_turn_rate),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_report(speed_report_type'{rsp_left_total, rsp_right_total, rsp_left_rpm,
                                            rsp_right_rpm, rsp_linear_speed, rsp_turn_rate});
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   task automatic send_counts(logic [CNT_W-1:0] left, logic [CNT_W-1:0] right);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < sender_idle_pct)
         gap = $urandom_range(1, 20);
      if (wait_for_drain && gap == 0)
         gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // hold off until every word in flight has come back
         while (wait_for_drain && sb.pending_speeds.size() != 0)
            @(posedge clock);
         wait_for_drain = 1'b0;
      end
      req_valid <= 1'b1;
      req_left_count <= left;
      req_right_count <= right;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_counts(left, right);
      words_sent++;
   endtask

   // Move both wheels by signed tick counts; the right counter runs negated.
   task automatic step_wheels(int dl, int dr);
      left_pos = left_pos + CNT_W'(dl);
      right_pos = right_pos - CNT_W'(dr);
      send_counts(left_pos, right_pos);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending_speeds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] stored;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << ADDR_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      stored = sb.set_register(idx, value);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      sb.compare_field("register readback", stored, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      settings_written++;
   endtask

   function automatic logic [DATA_W-1:0] pick_setting(int width, int high);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return DATA_W'((64'd1 << width) - 1);
         2: return DATA_W'(high);
         default: return DATA_W'($urandom_range(0, high));
      endcase
   endfunction

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run timed out with %0d speed words outstanding",
               $time, sb.pending_speeds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int speed_l;
      int speed_r;
      int pick;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: priming word, then full-range deltas and counter extremes
      left_pos = 16'h1234;
      right_pos = 16'hABCD;
      send_counts(left_pos, right_pos);
      step_wheels(32767, -32768);
      step_wheels(-32768, 32767);
      step_wheels(0, 0);
      step_wheels(1, -1);
      send_counts(16'hFFFF, 16'h0000);
      send_counts(16'h0000, 16'hFFFF);
      send_counts(16'h8000, 16'h7FFF);
      left_pos = 16'h8000;
      right_pos = 16'h7FFF;
      drain_results();

      // widest registers: alpha past one, rpm and both speeds saturate
      csr_write(REG_RPM_SCALE, 32'h01FF_FFFF);
      csr_write(REG_FILTER_ALPHA, 32'h0000_01FF);
      csr_write(REG_VELOCITY_FACTOR, 32'h000F_FFFF);
      csr_write(REG_ANGULAR_GAIN, 32'h00FF_FFFF);
      step_wheels(32767, -32768);
      step_wheels(32767, -32768);
      step_wheels(-32768, 32767);
      step_wheels(-32768, 32767);
      step_wheels(100, -100);
      drain_results();

      // alpha zero freezes the filter
      csr_write(REG_RPM_SCALE, 32'd16777216);
      csr_write(REG_FILTER_ALPHA, 32'd0);
      csr_write(REG_VELOCITY_FACTOR, 32'd1000000);
      step_wheels(32767, 32767);
      step_wheels(-5, 5);
      drain_results();

      // zero scale with full alpha drops the filter to zero
      csr_write(REG_RPM_SCALE, 32'd0);
      csr_write(REG_FILTER_ALPHA, 32'd256);
      csr_write(REG_VELOCITY_FACTOR, 32'd0);
      csr_write(REG_ANGULAR_GAIN, 32'd0);
      step_wheels(1000, -1000);
      step_wheels(1000, -1000);
      drain_results();

      csr_write(REG_RPM_SCALE, 32'd65536);
      csr_write(REG_FILTER_ALPHA, 32'd300);
      csr_write(REG_VELOCITY_FACTOR, 32'd3403);
      csr_write(REG_ANGULAR_GAIN, 32'd111848);
      step_wheels(40, -25);
      step_wheels(-300, 700);
      step_wheels(12, 12);

      for (int seg = 0; seg < 8; seg++) begin
         drain_results();
         case (seg % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin sender_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         csr_write(REG_RPM_SCALE, pick_setting(SCALE_W, 16777216));
         csr_write(REG_FILTER_ALPHA, pick_setting(ALPHA_W, 256));
         csr_write(REG_VELOCITY_FACTOR, pick_setting(VF_W, 1000000));
         csr_write(REG_ANGULAR_GAIN, pick_setting(GAIN_W, 16777215));
         speed_l = int'($urandom_range(0, 8000)) - 4000;
         speed_r = int'($urandom_range(0, 8000)) - 4000;
         for (int n = 0; n < 180; n++) begin
            wait_for_drain = ($urandom_range(0, 199) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // steady motion: speeds drift, counts advance with a little jitter
               speed_l += int'($urandom_range(0, 128)) - 64;
               speed_r += int'($urandom_range(0, 128)) - 64;
               speed_l = (speed_l > 30000) ? 30000 : ((speed_l < -30000) ? -30000 : speed_l);
               speed_r = (speed_r > 30000) ? 30000 : ((speed_r < -30000) ? -30000 : speed_r);
               step_wheels(speed_l + int'($urandom_range(0, 6)) - 3,
                           speed_r + int'($urandom_range(0, 6)) - 3);
            end else if (pick < 90) begin
               step_wheels(int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768);
            end else begin
               left_pos = CNT_W'($urandom);
               right_pos = CNT_W'($urandom);
               send_counts(left_pos, right_pos);
            end
         end
      end
      drain_results();

      $display("%0d count words driven, %0d speed words checked, %0d register writes",
               words_sent, sb.reports_checked, settings_written);
      $display("covered priming, alpha past one, rpm and speed saturation, four stall mixes");
      if (sb.mismatches == 0 && sb.pending_speeds.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
